// File: design/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, muted while reset is asserted.
`define ASEP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("angular separation check failed");

// Implication into the following cycle.
`define ASEP_ASSERT_NEXT(lbl, cond, conseq) \
  `ASEP_ASSERT(lbl, (cond) |=> (conseq))

`endif

// File: design/asep_pkg.sv
// Package: constants, types and arithmetic helpers of the angular separation core.
`default_nettype none
package asep_pkg;

  localparam longint Q30_ONE      = 64'sd1073741824;
  localparam longint Q30_PI       = 64'sd3373259426;
  localparam longint Q30_HALF_PI  = 64'sd1686629713;
  localparam longint Q30_TWO_PI   = 64'sd6746518852;
  localparam longint Q30_INV_GAIN = 64'sd652032874;
  localparam int     SQRT_STEPS   = 31;

  typedef struct packed {
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [33:0] z;
  } cord_t;

  typedef struct packed {
    logic [61:0] n;
    logic [61:0] res;
  } sqrt_t;

  function automatic logic [63:0] atan_q30(input logic [4:0] i);
    logic [63:0] v;
    case (i)
      5'd0:  v = 64'd843314857;
      5'd1:  v = 64'd497837829;
      5'd2:  v = 64'd263043837;
      5'd3:  v = 64'd133525159;
      5'd4:  v = 64'd67021687;
      5'd5:  v = 64'd33543516;
      5'd6:  v = 64'd16775851;
      5'd7:  v = 64'd8388437;
      5'd8:  v = 64'd4194283;
      5'd9:  v = 64'd2097149;
      5'd10: v = 64'd1048576;
      5'd11: v = 64'd524288;
      5'd12: v = 64'd262144;
      5'd13: v = 64'd131072;
      5'd14: v = 64'd65536;
      5'd15: v = 64'd32768;
      5'd16: v = 64'd16384;
      5'd17: v = 64'd8192;
      5'd18: v = 64'd4096;
      5'd19: v = 64'd2048;
      5'd20: v = 64'd1024;
      5'd21: v = 64'd512;
      5'd22: v = 64'd256;
      5'd23: v = 64'd128;
      5'd24: v = 64'd64;
      5'd25: v = 64'd32;
      5'd26: v = 64'd16;
      5'd27: v = 64'd8;
      5'd28: v = 64'd4;
      5'd29: v = 64'd2;
      5'd30: v = 64'd1;
      default: v = 64'd0;
    endcase
    return v;
  endfunction

  // Q30 product, magnitude rounded half up, sign applied afterwards
  function automatic logic signed [33:0] mulq(input logic signed [33:0] a,
                                              input logic signed [33:0] b);
    logic        neg;
    logic [33:0] aa;
    logic [33:0] ab;
    logic [65:0] p;
    logic [33:0] m;
    neg = a[33] ^ b[33];
    aa  = a[33] ? 34'(-a) : 34'(a);
    ab  = b[33] ? 34'(-b) : 34'(b);
    p   = 66'(aa[32:0]) * 66'(ab[32:0]) + 66'(64'd536870912);
    m   = p[63:30];
    return neg ? -$signed(m) : $signed(m);
  endfunction

endpackage
`default_nettype wire

// File: design/asep_red_cell.sv
// Range reduction cell: one conditional subtraction of a multiple of two pi.
`default_nettype none
module asep_red_cell #(
  parameter int          RW  = 35,
  parameter logic [RW-1:0] SUB = '0
) (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire logic [RW-1:0] v_i,
  output logic      [RW-1:0] v_o
);
  logic [RW-1:0] v_r;
  logic [RW-1:0] v_nxt;

  always_comb begin
    v_nxt = (v_i >= SUB) ? v_i - SUB : v_i;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v_r <= v_nxt;
    end
  end

  assign v_o = v_r;
endmodule
`default_nettype wire

// File: design/asep_rot_cell.sv
// CORDIC rotation cell: one micro-rotation towards z = 0.
`default_nettype none
module asep_rot_cell #(
  parameter int STEP = 0
) (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire asep_pkg::cord_t c_i,
  output asep_pkg::cord_t      c_o
);
  localparam logic [63:0] ATAN64 = asep_pkg::atan_q30(5'(STEP));
  localparam logic signed [33:0] ATAN = $signed(ATAN64[33:0]);

  asep_pkg::cord_t c_r;
  asep_pkg::cord_t c_nxt;
  logic signed [33:0] dx;
  logic signed [33:0] dy;

  always_comb begin
    dx = c_i.y >>> STEP;
    dy = c_i.x >>> STEP;
    if (!c_i.z[33]) begin
      c_nxt.x = c_i.x - dx;
      c_nxt.y = c_i.y + dy;
      c_nxt.z = c_i.z - ATAN;
    end else begin
      c_nxt.x = c_i.x + dx;
      c_nxt.y = c_i.y - dy;
      c_nxt.z = c_i.z + ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_r <= c_nxt;
    end
  end

  assign c_o = c_r;
endmodule
`default_nettype wire

// File: design/asep_sqrt_cell.sv
// Square root cell: decides one result bit of the restoring integer root.
`default_nettype none
module asep_sqrt_cell #(
  parameter int STEP = 0
) (
  input  wire logic            clk,
  input  wire logic            en,
  input  wire asep_pkg::sqrt_t s_i,
  output asep_pkg::sqrt_t      s_o
);
  localparam logic [61:0] BIT = 62'(1) << (60 - 2 * STEP);

  asep_pkg::sqrt_t s_r;
  asep_pkg::sqrt_t s_nxt;
  logic [61:0] trial;

  always_comb begin
    trial = s_i.res + BIT;
    if (s_i.n >= trial) begin
      s_nxt.n   = s_i.n - trial;
      s_nxt.res = (s_i.res >> 1) + BIT;
    end else begin
      s_nxt.n   = s_i.n;
      s_nxt.res = s_i.res >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_r <= s_nxt;
    end
  end

  assign s_o = s_r;
endmodule
`default_nettype wire

// File: design/asep_vec_cell.sv
// CORDIC vectoring cell: one micro-rotation towards y = 0, angle accumulated in z.
`default_nettype none
module asep_vec_cell #(
  parameter int STEP = 0
) (
  input  wire logic            clk,
  input  wire logic            en,
  input  wire asep_pkg::cord_t c_i,
  output asep_pkg::cord_t      c_o
);
  localparam logic [63:0] ATAN64 = asep_pkg::atan_q30(5'(STEP));
  localparam logic signed [33:0] ATAN = $signed(ATAN64[33:0]);

  asep_pkg::cord_t c_r;
  asep_pkg::cord_t c_nxt;
  logic signed [33:0] dx;
  logic signed [33:0] dy;

  always_comb begin
    dx = c_i.y >>> STEP;
    dy = c_i.x >>> STEP;
    if (c_i.y > 34'sd0) begin
      c_nxt.x = c_i.x + dx;
      c_nxt.y = c_i.y - dy;
      c_nxt.z = c_i.z + ATAN;
    end else begin
      c_nxt.x = c_i.x - dx;
      c_nxt.y = c_i.y + dy;
      c_nxt.z = c_i.z - ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_r <= c_nxt;
    end
  end

  assign c_o = c_r;
endmodule
`default_nettype wire

// File: design/angular_separation_core.sv
// Top level: pipelined great-circle separation of two sky positions.
//
// One transaction in and one out per cycle, fully pipelined. The pipeline is
// a row of range-reduction cells, one rotation CORDIC cell per step for each
// of the three angles, two product stages, a 31-cell square root and one
// vectoring CORDIC cell per step for the arc cosine. The whole row advances
// together; when a result is held at the output the input is held too.
// Result is acos of the clamped law-of-cosines term, clamped to [0, pi] and
// rounded to FRAC_BITS fraction bits.
`default_nettype none
module angular_separation_core #(
  parameter int FRAC_BITS    = 28,
  parameter int CORDIC_STEPS = 28
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // lon_a [31:0], lat_a [61:32], lon_b [93:62], lat_b [123:94], zero pad
  input  wire logic [127:0] in_tdata,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // separation [29:0], zero pad
  output logic [31:0]       out_tdata
);
  localparam int SH   = 30 - FRAC_BITS;
  localparam int DW   = 34 + SH;
  localparam int KR   = DW - 33;
  localparam int RW   = DW + 1;
  localparam int NRED = KR + 1;
  localparam int CS   = CORDIC_STEPS;
  localparam int NSQ  = asep_pkg::SQRT_STEPS;
  localparam int LAT  = NRED + 2 * CS + 42;
  localparam logic [63:0] OFS64 = 64'(asep_pkg::Q30_TWO_PI) << KR;
  localparam logic [32:0] PI33  = 33'(asep_pkg::Q30_PI);
  localparam logic [32:0] HPI33 = 33'(asep_pkg::Q30_HALF_PI);
  localparam logic [34:0] RND   = (SH > 0) ? (35'd1 << (SH - 1)) : 35'd0;

  logic en;
  logic [LAT-1:0] vld_r;

  assign en         = !vld_r[LAT-1] || out_tready;
  assign in_tready  = en;
  assign out_tvalid = vld_r[LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_tvalid};
    end
  end

  // input stage: scale to Q30, longitude difference
  logic signed [DW-1:0] lon_a_e, lon_b_e, lat_a_e, lat_b_e;
  logic signed [DW-1:0] ang_r [3];

  assign lon_a_e = DW'($signed(in_tdata[31:0]));
  assign lat_a_e = DW'($signed(in_tdata[61:32]));
  assign lon_b_e = DW'($signed(in_tdata[93:62]));
  assign lat_b_e = DW'($signed(in_tdata[123:94]));

  always_ff @(posedge clk) begin
    if (en) begin
      ang_r[0] <= lat_a_e <<< SH;
      ang_r[1] <= lat_b_e <<< SH;
      ang_r[2] <= (lon_a_e - lon_b_e) <<< SH;
    end
  end

  // reduction to [0, 2pi): offset positive, then subtract falling multiples
  logic [RW-1:0] red [3][NRED+1];
  logic [32:0]   fa_r [3];
  logic [2:0]    nb_a_r;
  logic [32:0]   fb_r [3];
  logic [5:0]    fl_r [CS+1];
  asep_pkg::cord_t rot [3][CS+1];

  genvar c, k;
  generate
    for (c = 0; c < 3; c++) begin : g_ang
      logic [RW-1:0] ofs_r;
      always_ff @(posedge clk) begin
        if (en) begin
          ofs_r <= {{(RW-DW){ang_r[c][DW-1]}}, ang_r[c]} + OFS64[RW-1:0];
        end
      end
      assign red[c][0] = ofs_r;
      for (k = 0; k < NRED; k++) begin : g_red
        localparam logic [63:0] SUB64 = 64'(asep_pkg::Q30_TWO_PI) << (KR - k);
        asep_red_cell #(.RW(RW), .SUB(SUB64[RW-1:0])) u_red (
          .clk (clk),
          .en  (en),
          .v_i (red[c][k]),
          .v_o (red[c][k+1])
        );
      end

      // fold into [0, pi/2]
      logic [32:0] r_in;
      assign r_in = red[c][NRED][32:0];
      always_ff @(posedge clk) begin
        if (en) begin
          if (r_in >= PI33) begin
            fa_r[c]   <= r_in - PI33;
            nb_a_r[c] <= 1'b1;
          end else begin
            fa_r[c]   <= r_in;
            nb_a_r[c] <= 1'b0;
          end
          fb_r[c]          <= (fa_r[c] > HPI33) ? PI33 - fa_r[c] : fa_r[c];
          fl_r[0][2*c]     <= nb_a_r[c];
          fl_r[0][2*c+1]   <= fa_r[c] > HPI33;
        end
      end

      assign rot[c][0].x = 34'(asep_pkg::Q30_INV_GAIN);
      assign rot[c][0].y = '0;
      assign rot[c][0].z = $signed({1'b0, fb_r[c]});
      for (k = 0; k < CS; k++) begin : g_rot
        asep_rot_cell #(.STEP(k)) u_rot (
          .clk (clk),
          .en  (en),
          .c_i (rot[c][k]),
          .c_o (rot[c][k+1])
        );
      end
    end

    for (k = 0; k < CS; k++) begin : g_fl
      always_ff @(posedge clk) begin
        if (en) begin
          fl_r[k+1] <= fl_r[k];
        end
      end
    end
  endgenerate

  // quadrant signs
  logic signed [33:0] sn_r [2];
  logic signed [33:0] cs_r [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        logic signed [33:0] xc;
        xc = fl_r[CS][2*i+1] ? -rot[i][CS].x : rot[i][CS].x;
        cs_r[i] <= fl_r[CS][2*i] ? -xc : xc;
        if (i < 2) begin
          sn_r[i] <= fl_r[CS][2*i] ? -rot[i][CS].y : rot[i][CS].y;
        end
      end
    end
  end

  // law of cosines term
  logic signed [33:0] p1_r, p2_r, cd_r, p1d_r, p3_r;
  logic signed [34:0] sum;
  logic signed [31:0] t_r;

  assign sum = 35'(p1d_r) + 35'(p3_r);

  always_ff @(posedge clk) begin
    if (en) begin
      p1_r  <= asep_pkg::mulq(sn_r[0], sn_r[1]);
      p2_r  <= asep_pkg::mulq(cs_r[0], cs_r[1]);
      cd_r  <= cs_r[2];
      p1d_r <= p1_r;
      p3_r  <= asep_pkg::mulq(p2_r, cd_r);
      if (sum > 35'(asep_pkg::Q30_ONE)) begin
        t_r <= 32'(asep_pkg::Q30_ONE);
      end else if (sum < -35'(asep_pkg::Q30_ONE)) begin
        t_r <= -32'(asep_pkg::Q30_ONE);
      end else begin
        t_r <= 32'(sum);
      end
    end
  end

  // sqrt(1 - t*t)
  logic [30:0]     ut;
  asep_pkg::sqrt_t sq [NSQ+1];
  asep_pkg::sqrt_t sq0_r;
  logic signed [31:0] td_r [NSQ+1];

  assign ut    = t_r[31] ? 31'(-t_r) : t_r[30:0];
  assign sq[0] = sq0_r;

  always_ff @(posedge clk) begin
    if (en) begin
      sq0_r.n   <= (62'd1 << 60) - 62'(ut) * 62'(ut);
      sq0_r.res <= '0;
      td_r[0]   <= t_r;
    end
  end

  generate
    for (k = 0; k < NSQ; k++) begin : g_sq
      asep_sqrt_cell #(.STEP(k)) u_sq (
        .clk (clk),
        .en  (en),
        .s_i (sq[k]),
        .s_o (sq[k+1])
      );
      always_ff @(posedge clk) begin
        if (en) begin
          td_r[k+1] <= td_r[k];
        end
      end
    end
  endgenerate

  // arc cosine by vectoring
  asep_pkg::cord_t vec [CS+1];
  asep_pkg::cord_t v0_r;
  logic signed [33:0] tv;
  logic signed [33:0] rv;

  assign tv     = 34'(td_r[NSQ]);
  assign rv     = $signed(sq[NSQ].res[33:0]);
  assign vec[0] = v0_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (tv[33]) begin
        v0_r.x <= rv;
        v0_r.y <= -tv;
        v0_r.z <= 34'(asep_pkg::Q30_HALF_PI);
      end else begin
        v0_r.x <= tv;
        v0_r.y <= rv;
        v0_r.z <= '0;
      end
    end
  end

  generate
    for (k = 0; k < CS; k++) begin : g_vec
      asep_vec_cell #(.STEP(k)) u_vec (
        .clk (clk),
        .en  (en),
        .c_i (vec[k]),
        .c_o (vec[k+1])
      );
    end
  endgenerate

  // clamp, round, output register
  logic signed [33:0] zf;
  logic [33:0] zc;
  logic [34:0] zr;
  logic [29:0] out_r;

  assign zf = vec[CS].z;
  assign zc = zf[33] ? 34'd0 :
              (zf > 34'(asep_pkg::Q30_PI)) ? 34'(asep_pkg::Q30_PI) : zf;
  assign zr = (35'(zc) + RND) >> SH;

  always_ff @(posedge clk) begin
    if (en) begin
      out_r <= zr[29:0];
    end
  end

  assign out_tdata = {2'b00, out_r};
endmodule
`default_nettype wire

// File: design/asep_checker.sv
// Port-level checker for the angular separation core, with its bind.
`default_nettype none
`include "assert_macros.svh"
module asep_checker (
  input wire logic         clk,
  input wire logic         rst_n,
  input wire logic         in_tvalid,
  input wire logic         in_tready,
  input wire logic [127:0] in_tdata,
  input wire logic         out_tvalid,
  input wire logic         out_tready,
  input wire logic [31:0]  out_tdata
);
  `ASEP_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  `ASEP_ASSERT(a_rng, out_tvalid |-> out_tdata[29:0] <= 30'd843314857)
  `ASEP_ASSERT(a_pad, out_tvalid |-> out_tdata[31:30] == 2'b00)
  `ASEP_ASSERT(a_rdy, in_tready == (!out_tvalid || out_tready))
endmodule

bind angular_separation_core asep_checker u_asep_checker (.*);
`default_nettype wire
